// File: hdl/tag_count_table_macros.svh
// Assertion macros used by the checker file of the tag count table.
// No dependencies; include with the bare file name.
`ifndef TAG_COUNT_TABLE_MACROS_SVH
`define TAG_COUNT_TABLE_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define TCT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tag_count_table: assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define TCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tag_count_table: assertion failed");

`endif

// File: hdl/tct_pkg.sv
// Package of the tag count table: sizes, codes and the structs between modules.
// No dependencies.
package tct_pkg;

  localparam int unsigned ENTRIES  = 16;
  localparam int unsigned KEY_BITS = 16;
  localparam int unsigned IDX_W    = $clog2(ENTRIES);
  localparam int unsigned CNT_W    = 31;
  localparam int unsigned AMT_W    = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned ENTRY_W  = KEY_BITS + CNT_W;
  localparam int unsigned S_DATA_W = ((KEY_BITS + AMT_W + 7) / 8) * 8;
  localparam int unsigned M_DATA_W = ((CNT_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_NONPOS  = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_FULL    = 3'd4,
    ST_SAT     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_e;

  // Outcome of the sweep over the table.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [CNT_W-1:0] hit_cnt;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } lookup_t;

  // Write-back and result for one item.
  typedef struct packed {
    logic              wr_en;
    logic              set_valid;
    logic              clr_valid;
    logic [IDX_W-1:0]  wr_idx;
    logic [CNT_W-1:0]  wr_count;
    logic [CNT_W-1:0]  count;
    logic [STAT_W-1:0] status;
  } update_t;

endpackage

// File: hdl/tct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/tct_alu.sv
// Count arithmetic of the tag count table: saturating add, remove, status.
// Depends on tct_pkg.
module tct_alu (
  input  logic [tct_pkg::OP_W-1:0]     op_i,
  input  logic [tct_pkg::KEY_BITS-1:0] key_i,
  input  logic [tct_pkg::AMT_W-1:0]    amount_i,
  input  tct_pkg::lookup_t             lookup_i,
  output tct_pkg::update_t             update_o
);

  logic                      positive;
  logic [tct_pkg::CNT_W-1:0] cur_cnt;
  logic [tct_pkg::CNT_W:0]   sum;
  logic                      rm_all;

  assign positive = !amount_i[tct_pkg::AMT_W-1] && (|amount_i);
  assign cur_cnt  = lookup_i.hit ? lookup_i.hit_cnt : '0;
  assign sum      = {1'b0, lookup_i.hit_cnt} + {1'b0, amount_i[tct_pkg::CNT_W-1:0]};
  assign rm_all   = ({1'b0, lookup_i.hit_cnt} <= amount_i);

  always_comb begin
    update_o        = '0;
    update_o.status = tct_pkg::ST_OK;
    if (key_i == '0) begin
      update_o.status = tct_pkg::ST_INVALID;
    end else begin
      unique case (op_i)
        tct_pkg::OP_ADD: begin
          if (!positive) begin
            update_o.status = tct_pkg::ST_NONPOS;
            update_o.count  = cur_cnt;
          end else if (lookup_i.hit) begin
            update_o.wr_en  = 1'b1;
            update_o.wr_idx = lookup_i.hit_idx;
            if (sum[tct_pkg::CNT_W]) begin
              update_o.wr_count = tct_pkg::COUNT_MAX;
              update_o.status   = tct_pkg::ST_SAT;
            end else begin
              update_o.wr_count = sum[tct_pkg::CNT_W-1:0];
            end
            update_o.count = update_o.wr_count;
          end else if (lookup_i.free) begin
            update_o.wr_en     = 1'b1;
            update_o.set_valid = 1'b1;
            update_o.wr_idx    = lookup_i.free_idx;
            update_o.wr_count  = amount_i[tct_pkg::CNT_W-1:0];
            update_o.count     = amount_i[tct_pkg::CNT_W-1:0];
          end else begin
            update_o.status = tct_pkg::ST_FULL;
          end
        end
        tct_pkg::OP_REMOVE: begin
          if (!positive) begin
            update_o.status = tct_pkg::ST_NONPOS;
            update_o.count  = cur_cnt;
          end else if (!lookup_i.hit) begin
            update_o.status = tct_pkg::ST_ABSENT;
          end else if (rm_all) begin
            update_o.clr_valid = 1'b1;
            update_o.wr_idx    = lookup_i.hit_idx;
          end else begin
            update_o.wr_en    = 1'b1;
            update_o.wr_idx   = lookup_i.hit_idx;
            update_o.wr_count = lookup_i.hit_cnt - amount_i[tct_pkg::CNT_W-1:0];
            update_o.count    = update_o.wr_count;
          end
        end
        default: begin
          // Query, and the unused code that behaves as one.
          if (lookup_i.hit) begin
            update_o.count = lookup_i.hit_cnt;
          end else begin
            update_o.status = tct_pkg::ST_ABSENT;
          end
        end
      endcase
    end
  end

endmodule

// File: hdl/tct_ctrl.sv
// Sequencer of the tag count table: table sweep, key compare, valid bits.
// Depends on tct_pkg; drives the read port of tct_ram.
module tct_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         out_free_i,
  input  logic [tct_pkg::KEY_BITS-1:0] key_i,
  input  logic [tct_pkg::ENTRY_W-1:0]  ram_rdata_i,
  input  tct_pkg::update_t             update_i,
  output logic [tct_pkg::IDX_W-1:0]    ram_raddr_o,
  output logic                         in_ready_o,
  output logic                         done_o,
  output tct_pkg::lookup_t             lookup_o
);

  tct_pkg::state_e              state_q, state_d;
  logic [tct_pkg::IDX_W-1:0]    idx_q;
  logic                         chk_vld_q;
  logic [tct_pkg::IDX_W-1:0]    chk_idx_q;
  logic [tct_pkg::ENTRIES-1:0]  valid_q;
  tct_pkg::lookup_t             lookup_q;
  logic                         accept;
  logic                         key_match;

  assign accept    = in_ready_o && in_valid_i;
  assign key_match = ram_rdata_i[tct_pkg::ENTRY_W-1:tct_pkg::CNT_W] == key_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tct_pkg::S_IDLE: if (in_valid_i) state_d = tct_pkg::S_SCAN;
      tct_pkg::S_SCAN: begin
        if (idx_q == tct_pkg::IDX_W'(tct_pkg::ENTRIES - 1)) state_d = tct_pkg::S_LAST;
      end
      tct_pkg::S_LAST: state_d = tct_pkg::S_DONE;
      tct_pkg::S_DONE: if (out_free_i) state_d = tct_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == tct_pkg::S_IDLE);
    done_o      = (state_q == tct_pkg::S_DONE) && out_free_i;
    ram_raddr_o = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tct_pkg::S_IDLE;
      idx_q     <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
      valid_q   <= '0;
      lookup_q  <= '0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= (state_q == tct_pkg::S_SCAN);
      chk_idx_q <= idx_q;
      if (accept) begin
        idx_q    <= '0;
        lookup_q <= '0;
      end else begin
        if (state_q == tct_pkg::S_SCAN) idx_q <= idx_q + 1'b1;
        // Compare the entry read in the previous cycle; keys are unique.
        if (chk_vld_q) begin
          if (valid_q[chk_idx_q] && key_match) begin
            lookup_q.hit     <= 1'b1;
            lookup_q.hit_idx <= chk_idx_q;
            lookup_q.hit_cnt <= ram_rdata_i[tct_pkg::CNT_W-1:0];
          end
          if (!valid_q[chk_idx_q] && !lookup_q.free) begin
            lookup_q.free     <= 1'b1;
            lookup_q.free_idx <= chk_idx_q;
          end
        end
      end
      if (done_o && update_i.set_valid) valid_q[update_i.wr_idx] <= 1'b1;
      if (done_o && update_i.clr_valid) valid_q[update_i.wr_idx] <= 1'b0;
    end
  end

  assign lookup_o = lookup_q;

endmodule

// File: hdl/tag_count_table.sv
// Top level of the tag count table: item registers, output register, wiring.
// Depends on tct_pkg, tct_ram, tct_alu and tct_ctrl.
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------
//   s_axis   | in        | tuser: operation; tdata: key, amount
//   m_axis   | out       | tuser: status;    tdata: count
//
// An item is handled in steps: accept it, sweep the key/count RAM entry by
// entry through its single read port, compare the last entry read, then write
// back and load the result. A new item is taken only once the last is done.
// Reset clears the valid bits, so the table starts empty with no clearing pass.
// A stalled m_axis holds the next item in the write-back step until the output
// register frees; the sweep and write-back never touch the RAM in the same
// cycle, so no forwarding is needed.
module tag_count_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [15:0] key, [47:16] amount
  input  logic [tct_pkg::S_DATA_W-1:0] s_axis_tdata,
  // [1:0] operation
  input  logic [tct_pkg::OP_W-1:0]     s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [30:0] count, [31] zero
  output logic [tct_pkg::M_DATA_W-1:0] m_axis_tdata,
  // [2:0] status
  output logic [tct_pkg::STAT_W-1:0]   m_axis_tuser
);

  // Item held for the whole sweep.
  logic [tct_pkg::OP_W-1:0]     op_q;
  logic [tct_pkg::KEY_BITS-1:0] key_q;
  logic [tct_pkg::AMT_W-1:0]    amount_q;

  // Output register.
  logic                         m_valid_q;
  logic [tct_pkg::CNT_W-1:0]    m_count_q;
  logic [tct_pkg::STAT_W-1:0]   m_status_q;

  logic                         out_free;
  logic                         done;
  logic [tct_pkg::IDX_W-1:0]    ram_raddr;
  logic [tct_pkg::ENTRY_W-1:0]  ram_rdata;
  tct_pkg::lookup_t             lookup;
  tct_pkg::update_t             update;

  // Output slot takes a new item when empty or draining this cycle.
  assign out_free = !m_valid_q || m_axis_tready;

  tct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_free_i  (out_free),
    .key_i       (key_q),
    .ram_rdata_i (ram_rdata),
    .update_i    (update),
    .ram_raddr_o (ram_raddr),
    .in_ready_o  (s_axis_tready),
    .done_o      (done),
    .lookup_o    (lookup)
  );

  // Each entry packs the key above its count.
  tct_ram #(
    .WIDTH (tct_pkg::ENTRY_W),
    .DEPTH (tct_pkg::ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (done && update.wr_en),
    .waddr_i (update.wr_idx),
    .wdata_i ({key_q, update.wr_count}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tct_alu u_alu (
    .op_i     (op_q),
    .key_i    (key_q),
    .amount_i (amount_q),
    .lookup_i (lookup),
    .update_o (update)
  );

  // Capture the item on acceptance; hold it until the next one.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q     <= s_axis_tuser;
      key_q    <= s_axis_tdata[tct_pkg::KEY_BITS-1:0];
      amount_q <= s_axis_tdata[tct_pkg::KEY_BITS +: tct_pkg::AMT_W];
    end
  end

  // Load the result at write-back; drop the valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      m_count_q  <= update.count;
      m_status_q <= update.status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = tct_pkg::M_DATA_W'(m_count_q);
  assign m_axis_tuser  = m_status_q;

endmodule

// File: hdl/tct_checker.sv
// Port-level checker of the tag count table, bound to the top level.
// Depends on tct_pkg and tag_count_table_macros.svh.
`include "tag_count_table_macros.svh"

module tct_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [tct_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic [tct_pkg::STAT_W-1:0]   m_axis_tuser
);

  // A stalled result holds.
  `TCT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // One item at a time: no acceptance right after another.
  `TCT_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // Invalid, absent and dropped keys report a zero count.
  `TCT_ASSERT_IMPLIES(a_zero_count, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == tct_pkg::ST_INVALID || m_axis_tuser == tct_pkg::ST_ABSENT || m_axis_tuser == tct_pkg::ST_FULL), m_axis_tdata[tct_pkg::CNT_W-1:0] == '0)

  // Saturation reports the ceiling.
  `TCT_ASSERT_IMPLIES(a_sat_count, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == tct_pkg::ST_SAT, m_axis_tdata[tct_pkg::CNT_W-1:0] == tct_pkg::COUNT_MAX)

endmodule

bind tag_count_table tct_checker u_tct_checker (.*);

// File: dv/tag_count_checker.sv
`timescale 1ns / 100ps
// Checker for the tag count table: watches both stream channels and keeps its own
// copy of the table. Compares each result with the oldest expected one.
// Depends on tct_pkg.
module tag_count_checker
  import tct_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [S_DATA_W-1:0] s_data_i,
  input  logic [OP_W-1:0]     s_user_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [M_DATA_W-1:0] m_data_i,
  input  logic [STAT_W-1:0]   m_user_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         results_o,
  output logic [5:0]          status_seen_o
);

  typedef struct packed {
    logic [CNT_W-1:0] count;
    status_e          status;
  } tally_t;

  // Mirror of the table.
  logic [KEY_BITS-1:0] slot_key   [ENTRIES];
  logic [CNT_W-1:0]    slot_count [ENTRIES];
  logic                slot_used  [ENTRIES];

  tally_t      count_status_q[$];
  int unsigned fails;
  int unsigned results;
  logic [5:0]  seen;

  // Apply one item to the mirror and return the count and status it yields.
  function automatic tally_t apply_tag_op(input logic [OP_W-1:0]     op,
                                          input logic [KEY_BITS-1:0] key,
                                          input logic [AMT_W-1:0]    amt);
    tally_t         res;
    int             hit;
    int             vacant;
    logic           positive;
    logic [AMT_W:0] sum;
    res.count  = '0;
    res.status = ST_OK;
    if (key == '0) begin
      res.status = ST_INVALID;
      return res;
    end
    hit    = -1;
    vacant = -1;
    for (int i = 0; i < int'(ENTRIES); i++) begin
      if (slot_used[i] && slot_key[i] == key && hit < 0) hit = i;
      if (!slot_used[i] && vacant < 0) vacant = i;
    end
    positive = !amt[AMT_W-1] && amt != '0;
    case (op)
      OP_ADD: begin
        if (!positive) begin
          res.status = ST_NONPOS;
          if (hit >= 0) res.count = slot_count[hit];
        end else if (hit >= 0) begin
          sum = {1'b0, amt} + (AMT_W+1)'(slot_count[hit]);
          if (sum > (AMT_W+1)'(COUNT_MAX)) begin
            sum        = (AMT_W+1)'(COUNT_MAX);
            res.status = ST_SAT;
          end
          slot_count[hit] = sum[CNT_W-1:0];
          res.count       = sum[CNT_W-1:0];
        end else if (vacant < 0) begin
          res.status = ST_FULL;
        end else begin
          slot_used[vacant]  = 1'b1;
          slot_key[vacant]   = key;
          slot_count[vacant] = amt[CNT_W-1:0];
          res.count          = amt[CNT_W-1:0];
        end
      end
      OP_REMOVE: begin
        if (!positive) begin
          res.status = ST_NONPOS;
          if (hit >= 0) res.count = slot_count[hit];
        end else if (hit < 0) begin
          res.status = ST_ABSENT;
        end else if (slot_count[hit] <= amt[CNT_W-1:0]) begin
          slot_used[hit] = 1'b0;
        end else begin
          slot_count[hit] = slot_count[hit] - amt[CNT_W-1:0];
          res.count       = slot_count[hit];
        end
      end
      default: begin
        // query, and the spare code that behaves as one
        if (hit >= 0) res.count = slot_count[hit];
        else res.status = ST_ABSENT;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t want;
    if (!rst_ni) begin
      for (int i = 0; i < int'(ENTRIES); i++) slot_used[i] = 1'b0;
      count_status_q.delete();
      fails   = 0;
      results = 0;
      seen    = '0;
    end else begin
      if (s_valid_i && s_ready_i)
        count_status_q.push_back(apply_tag_op(s_user_i, s_data_i[KEY_BITS-1:0],
                                              s_data_i[KEY_BITS +: AMT_W]));
      if (m_valid_i && m_ready_i) begin
        results++;
        if (count_status_q.size() == 0) begin
          $error("unexpected result: count %0d, status %0d",
                 m_data_i[CNT_W-1:0], m_user_i);
          fails++;
        end else begin
          want = count_status_q.pop_front();
          seen[want.status] = 1'b1;
          if (m_data_i[CNT_W-1:0] !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, m_data_i[CNT_W-1:0]);
            fails++;
          end
          if (m_data_i[M_DATA_W-1:CNT_W] !== '0) begin
            $error("count padding: expected 0, got %0d", m_data_i[M_DATA_W-1:CNT_W]);
            fails++;
          end
          if (m_user_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_user_i);
            fails++;
          end
        end
      end
    end
    fail_count_o  <= fails;
    pending_o     <= count_status_q.size();
    results_o     <= results;
    status_seen_o <= seen;
  end

endmodule

// File: dv/tag_count_table_tb.sv
`timescale 1ns / 100ps
// Testbench top of the tag count table: clock, reset, item stimulus, result stalls.
// Depends on tct_pkg, tag_count_table and tag_count_checker.
module tag_count_table_tb;
  import tct_pkg::*;

  // Operation code left unused by the block; it must act as a query.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  wire                 s_axis_tready;
  // [15:0] key, [47:16] amount
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  // [1:0] operation
  logic [OP_W-1:0]     s_axis_tuser = '0;
  wire                 m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [30:0] count, [31] zero
  wire [M_DATA_W-1:0]  m_axis_tdata;
  // [2:0] status
  wire [STAT_W-1:0]    m_axis_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;
  logic [5:0]  status_seen;

  // Sender pacing: items left in the current burst and the longest gap between bursts.
  int unsigned burst_left = 0;
  int unsigned gap_max    = 24;
  int unsigned items_sent = 0;
  int unsigned op_tally [4] = '{0, 0, 0, 0};

  // Receiver pacing.
  int unsigned stall_left = 0;
  int unsigned stall_pct  = 0;
  int unsigned phase_left = 0;

  always #10 clk = ~clk;

  tag_count_table dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  tag_count_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_i     (s_axis_tready),
    .s_data_i      (s_axis_tdata),
    .s_user_i      (s_axis_tuser),
    .m_valid_i     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_i      (m_axis_tdata),
    .m_user_i      (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .results_o     (results),
    .status_seen_o (status_seen)
  );

  // Receiver: switch between phases of no, light and heavy stalling; each stall
  // holds tready low for a random stretch.
  always @(posedge clk) begin
    if (phase_left == 0) begin
      phase_left <= $urandom_range(64, 512);
      case ($urandom_range(0, 2))
        0:       stall_pct <= 0;
        1:       stall_pct <= 25;
        default: stall_pct <= 60;
      endcase
    end else begin
      phase_left <= phase_left - 1;
    end
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 24);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one item and hold it until accepted. A gap of random noise with tvalid
  // low may go in front of each burst. Valid is lowered after a handshake only
  // when a gap or a drain follows, so it stays high across a burst.
  task automatic send_tag_op(input logic [OP_W-1:0]     op,
                             input logic [KEY_BITS-1:0] key,
                             input logic [AMT_W-1:0]    amount);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
      repeat (gap) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= S_DATA_W'({$urandom(), $urandom()});
        s_axis_tuser  <= OP_W'($urandom());
        @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {amount, key};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    op_tally[op]++;
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    burst_left = 0;
  endtask

  // Mostly small amounts so counts build up and run down, with the edges of the
  // signed range and full random words mixed in.
  function automatic logic [AMT_W-1:0] pick_amount(input bit to_remove);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return to_remove ? $urandom_range(1, 30) : $urandom_range(1, 200);
    if (sel < 55) return $urandom_range(1, 1 << 20);
    if (sel < 65) return 32'h7FFF_FFFF - $urandom_range(0, 1023);
    if (sel < 75) return {1'b0, 31'($urandom())};
    if (sel < 80) return '0;
    if (sel < 85) return 32'h8000_0000;
    if (sel < 92) return {1'b1, 31'($urandom())};
    return $urandom();
  endfunction

  // One stretch of random traffic over a small pool of keys, so the same keys
  // are hit again and, with large pools, the table runs full.
  task automatic run_episode();
    logic [KEY_BITS-1:0] key_pool [32];
    logic [KEY_BITS-1:0] key;
    logic [OP_W-1:0]     op;
    int unsigned         pool_n;
    int unsigned         add_pct;
    int unsigned         sel;
    int unsigned         len;
    pool_n  = $urandom_range(2, 30);
    add_pct = $urandom_range(30, 65);
    len     = $urandom_range(40, 200);
    case ($urandom_range(0, 2))
      0:       gap_max = 0;
      1:       gap_max = 4;
      default: gap_max = 24;
    endcase
    for (int p = 0; p < int'(pool_n); p++) begin
      case ($urandom_range(0, 9))
        0:       key_pool[p] = '1;
        1:       key_pool[p] = KEY_BITS'(1);
        default: key_pool[p] = KEY_BITS'($urandom_range(1, (1 << KEY_BITS) - 1));
      endcase
    end
    repeat (len) begin
      sel = $urandom_range(0, 99);
      if (sel < add_pct) op = OP_ADD;
      else if (sel < add_pct + 25) op = OP_REMOVE;
      else if (sel < 95) op = OP_QUERY;
      else op = OP_SPARE;
      sel = $urandom_range(0, 99);
      if (sel < 4) key = '0;
      else if (sel < 9) key = KEY_BITS'($urandom());
      else key = key_pool[$urandom_range(0, pool_n - 1)];
      send_tag_op(op, key, pick_amount(op == OP_REMOVE));
    end
  endtask

  initial begin
    int unsigned episode;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: invalid key on add, remove and the spare code.
    send_tag_op(OP_ADD,    '0, 32'd5);
    send_tag_op(OP_REMOVE, '0, 32'd5);
    send_tag_op(OP_SPARE,  '0, '0);
    // Absent key, nonpositive amounts, then saturation at the top of the count.
    send_tag_op(OP_QUERY,  16'h0001, '0);
    send_tag_op(OP_REMOVE, 16'h0001, 32'd1);
    send_tag_op(OP_ADD,    16'h0001, '0);
    send_tag_op(OP_ADD,    16'h0001, 32'hFFFF_FFFF);
    send_tag_op(OP_ADD,    16'h0001, 32'h7FFF_FFFF);
    send_tag_op(OP_ADD,    16'h0001, 32'd1);
    // Largest key: partial removal, query through the spare code, full removal.
    send_tag_op(OP_ADD,    16'hFFFF, 32'h8000_0000);
    send_tag_op(OP_ADD,    16'hFFFF, 32'd10);
    send_tag_op(OP_REMOVE, 16'hFFFF, '0);
    send_tag_op(OP_REMOVE, 16'hFFFF, 32'd3);
    send_tag_op(OP_SPARE,  16'hFFFF, '0);
    send_tag_op(OP_REMOVE, 16'hFFFF, 32'd7);
    send_tag_op(OP_QUERY,  16'hFFFF, '0);
    send_tag_op(OP_REMOVE, 16'h0001, 32'h7FFF_FFFF);
    drain_results();

    // Random episodes; drain now and then so the table is also seen quiet.
    episode = 0;
    while (items_sent < 1900) begin
      run_episode();
      episode++;
      if (episode % 5 == 0) drain_results();
    end

    drain_results();
    repeat (40) @(posedge clk);
    $display("Sent %0d items (add %0d, remove %0d, query %0d, spare code %0d), checked %0d results.",
             items_sent, op_tally[OP_ADD], op_tally[OP_REMOVE], op_tally[OP_QUERY],
             op_tally[OP_SPARE], results);
    $display("Statuses seen, ok upward: %b", status_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #15_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: tag_count_table.f
+incdir+hdl
hdl/tct_pkg.sv
hdl/tct_ram.sv
hdl/tct_alu.sv
hdl/tct_ctrl.sv
hdl/tag_count_table.sv
hdl/tct_checker.sv
dv/tag_count_checker.sv
dv/tag_count_table_tb.sv
